// File: hdl/popcount_rotate_random_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the popcount-rotate generator
// Clocked checks with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef POPCOUNT_ROTATE_RANDOM_GENERATOR_TOP_MACROS_SVH
`define POPCOUNT_ROTATE_RANDOM_GENERATOR_TOP_MACROS_SVH

// Check a property while out of reset.
`define PRRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PRRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/prrg_pkg.sv
// ----------------------------------------------------------------------------
// prrg_pkg
// Types, constants and key table of the popcount-rotate generator.
// ----------------------------------------------------------------------------
`default_nettype none

package prrg_pkg;

  localparam int ROUNDS = 1024;
  // Round counter keeps at least three bits for the key index.
  localparam int RND_W = (ROUNDS > 8) ? $clog2(ROUNDS) : 3;

  localparam logic [63:0] SEED_RESET = 64'he93b0127190b637d;

  typedef logic [63:0]      seed_t;
  typedef logic [RND_W-1:0] rnd_t;
  typedef logic [6:0]       pcnt_t;

  function automatic seed_t mix_key(input logic [2:0] idx);
    seed_t k;
    case (idx)
      3'd0:    k = 64'hfacc5f414e14dd83;
      3'd1:    k = 64'hec4147d55893b745;
      3'd2:    k = 64'h61afc36079090ade;
      3'd3:    k = 64'h2808c6edba6d6b04;
      3'd4:    k = 64'hd15ec9d62e69e632;
      3'd5:    k = 64'hfac8fd8eaf507ce6;
      3'd6:    k = 64'hb7ea08d5647db77f;
      3'd7:    k = 64'hcc419f9c6b2256e9;
      default: k = 64'hfacc5f414e14dd83;
    endcase
    return k;
  endfunction

  // Key plus round index, wrapping modulo 2^64.
  function automatic seed_t round_mix(input rnd_t idx);
    return mix_key(idx[2:0]) + seed_t'(idx);
  endfunction

endpackage

`default_nettype wire

// File: hdl/prrg_if.sv
// ----------------------------------------------------------------------------
// prrg channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface prrg_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface prrg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/prrg_round.sv
// ----------------------------------------------------------------------------
// prrg_round
// One mixing round: XOR with the round mix, then rotate left by popcount.
// ----------------------------------------------------------------------------
`default_nettype none

module prrg_round (
  input  prrg_pkg::seed_t seed_i,
  input  prrg_pkg::seed_t mix_i,
  output prrg_pkg::seed_t seed_o
);

  prrg_pkg::seed_t mixed;
  prrg_pkg::pcnt_t ones;
  logic [127:0]    dbl;

  logic [1:0]      sum2  [32];
  logic [2:0]      sum4  [16];
  logic [3:0]      sum8  [8];
  logic [4:0]      sum16 [4];
  logic [5:0]      sum32 [2];

  assign mixed = seed_i ^ mix_i;

  // Count ones with a balanced adder tree.
  always_comb begin
    for (int k = 0; k < 32; k++) begin
      sum2[k] = {1'b0, mixed[2*k]} + {1'b0, mixed[2*k+1]};
    end
    for (int k = 0; k < 16; k++) begin
      sum4[k] = {1'b0, sum2[2*k]} + {1'b0, sum2[2*k+1]};
    end
    for (int k = 0; k < 8; k++) begin
      sum8[k] = {1'b0, sum4[2*k]} + {1'b0, sum4[2*k+1]};
    end
    for (int k = 0; k < 4; k++) begin
      sum16[k] = {1'b0, sum8[2*k]} + {1'b0, sum8[2*k+1]};
    end
    for (int k = 0; k < 2; k++) begin
      sum32[k] = {1'b0, sum16[2*k]} + {1'b0, sum16[2*k+1]};
    end
    ones = {1'b0, sum32[0]} + {1'b0, sum32[1]};
  end

  // A count of 64 wraps to a shift of 0, same as no change.
  assign dbl    = {mixed, mixed} << ones[5:0];
  assign seed_o = dbl[127:64];

endmodule

`default_nettype wire

// File: hdl/popcount_rotate_random_generator_top.sv
// ----------------------------------------------------------------------------
// popcount_rotate_random_generator_top
// Seeded generator: each draw runs XOR/popcount-rotate rounds on the seed.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries request items (op, seed_value); out_ch carries one result
//   item (value) per request. op = 1 loads seed_value as the new seed and
//   echoes it; op = 0 draws: the seed goes through ROUNDS rounds and the
//   final seed is kept and returned.
//   A load shows its result in the cycle after acceptance. A draw is
//   accepted, then runs its ROUNDS rounds at one round per cycle through
//   the single round unit, since each round depends on the popcount of the
//   previous one. in_ch.ready is low while rounds run, so no new request is
//   taken until a draw is done; loads go one per cycle while out_ch drains.
//   Results sit in an output register; a new request is taken while it is
//   still held, as long as it drains in the same cycle or is empty.
//   If out_ch stalls at the end of a draw, the last round holds until the
//   register frees. Reset (rst_n low, synchronous) drops any pending result
//   and restores the seed to e93b0127190b637d.
// ----------------------------------------------------------------------------
`default_nettype none

`include "popcount_rotate_random_generator_top_macros.svh"

module popcount_rotate_random_generator_top (
  input wire logic     clk,
  input wire logic     rst_n,
  prrg_in_if.sink      in_ch,
  prrg_out_if.source   out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r, state_nxt;
  prrg_pkg::rnd_t    cnt_r, cnt_nxt;
  prrg_pkg::seed_t   seed_r, seed_nxt;
  prrg_pkg::seed_t   mix_r, mix_nxt;
  prrg_pkg::seed_t   value_r, value_nxt;
  logic              out_valid_r, out_valid_nxt;

  prrg_pkg::seed_t   round_seed;
  logic              slot_free;
  logic              in_acc;
  logic              last_rnd;
  logic              commit;

  prrg_round u_round (
    .seed_i (seed_r),
    .mix_i  (mix_r),
    .seed_o (round_seed)
  );

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && slot_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign last_rnd     = (cnt_r == prrg_pkg::rnd_t'(prrg_pkg::ROUNDS - 1));
  assign commit       = (state_r == ST_RUN) && last_rnd && slot_free;

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = value_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seed_nxt      = seed_r;
    mix_nxt       = mix_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.op) begin
            seed_nxt      = in_ch.seed_value;
            value_nxt     = in_ch.seed_value;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_RUN;
            cnt_nxt   = '0;
            mix_nxt   = prrg_pkg::round_mix('0);
          end
        end
      end
      ST_RUN: begin
        if (commit) begin
          seed_nxt      = round_seed;
          value_nxt     = round_seed;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!last_rnd) begin
          // advance one round; precompute the next round's mix
          seed_nxt = round_seed;
          cnt_nxt  = cnt_r + 1'b1;
          mix_nxt  = prrg_pkg::round_mix(cnt_r + 1'b1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seed_r      <= prrg_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_r   <= mix_nxt;
    value_r <= value_nxt;
  end

  `PRRG_ASSERT(a_busy_not_ready, (state_r == ST_RUN) |-> !in_ch.ready, "ready during rounds")
  `PRRG_ASSERT(a_mix_tracks_cnt, (state_r == ST_RUN) |-> (mix_r == prrg_pkg::round_mix(cnt_r)), "round mix out of step")
  `PRRG_ASSERT(a_load_echo, (in_acc && in_ch.op) |=> (out_valid_r && seed_r == value_r && value_r == $past(in_ch.seed_value)), "load not echoed")
  `PRRG_ASSERT(a_commit_done, commit |=> (state_r == ST_IDLE && out_valid_r && value_r == seed_r), "draw not delivered")
  `PRRG_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset did not clear")

endmodule

`default_nettype wire

// File: dv/popcount_rotate_random_generator_top_tb.sv
// ----------------------------------------------------------------------------
// popcount_rotate_random_generator_top_tb
// Drives load and draw requests with random gaps on both channels, predicts
// each result with an in-bench round model and checks every value in order.
// ----------------------------------------------------------------------------
module popcount_rotate_random_generator_top_tb;

  localparam int          CLK_PERIOD  = 12;
  localparam int          RAND_ITEMS  = 560;
  localparam int          SHOW_ERRORS = 10;
  localparam logic [63:0] SEED_INIT   = 64'he93b0127190b637d;
  localparam logic [63:0] ALL_ONES    = 64'hffffffffffffffff;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [63:0] ROUND_KEYS [8] = '{
    64'hfacc5f414e14dd83, 64'hec4147d55893b745,
    64'h61afc36079090ade, 64'h2808c6edba6d6b04,
    64'hd15ec9d62e69e632, 64'hfac8fd8eaf507ce6,
    64'hb7ea08d5647db77f, 64'hcc419f9c6b2256e9
  };

  typedef struct {
    logic        op;
    logic [63:0] seed_value;
    int unsigned pre_idle;
    bit          drain;
  } req_t;

  logic clk;
  logic rst_n;

  prrg_in_if  in_ch ();
  prrg_out_if out_ch ();

  popcount_rotate_random_generator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  req_t        req_q[$];
  logic [63:0] value_q[$];
  req_t        cur_req;
  logic [63:0] model_seed = SEED_INIT;
  int unsigned idle_cnt;
  int unsigned stall_left;
  int unsigned calm_left;
  bit          rx_calm;
  int unsigned err_cnt;

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_seed();
    logic [63:0] bit_mask;
    bit_mask = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return bit_mask;
      3:       return ~bit_mask;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Seed after one draw: every round mixes in a key plus the round index,
  // then rotates left by the popcount of the mixed seed.
  function automatic logic [63:0] seed_after_draw(input logic [63:0] s_in);
    logic [63:0] s;
    int unsigned ones;
    s = s_in;
    for (int unsigned i = 0; i < prrg_pkg::ROUNDS; i++) begin
      s = s ^ (ROUND_KEYS[i % 8] + 64'(i));
      ones = $countones(s);
      if (ones != 0 && ones != 64) s = (s << ones) | (s >> (64 - ones));
    end
    return s;
  endfunction

  task automatic add_req(input logic op, input logic [63:0] val,
                         input int unsigned pre_idle, input bit drain);
    req_t r;
    r.op         = op;
    r.seed_value = val;
    r.pre_idle   = pre_idle;
    r.drain      = drain;
    req_q.push_back(r);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (cur_req.op == OP_LOAD) model_seed = cur_req.seed_value;
        else                       model_seed = seed_after_draw(model_seed);
        value_q.push_back(model_seed);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the item until taken
      end else if (req_q.size() != 0 && idle_cnt >= req_q[0].pre_idle &&
                   !(req_q[0].drain && value_q.size() != 0)) begin
        cur_req = req_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.op         <= cur_req.op;
        in_ch.seed_value <= cur_req.seed_value;
        idle_cnt = 0;
      end else begin
        in_ch.valid      <= 1'b0;
        in_ch.op         <= 1'($urandom_range(0, 1));
        in_ch.seed_value <= {$urandom, $urandom};
        if (req_q.size() != 0 && idle_cnt < req_q[0].pre_idle) idle_cnt++;
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
      rx_calm    = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (value_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_ERRORS)
            $display("unexpected result item: value %h", out_ch.value);
        end else begin
          if (out_ch.value !== value_q[0]) begin
            err_cnt++;
            if (err_cnt <= SHOW_ERRORS)
              $display("value error: expected %h, got %h", value_q[0], out_ch.value);
          end
          void'(value_q.pop_front());
        end
      end
      if (calm_left == 0) begin
        rx_calm   = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 3000);
      end else begin
        calm_left--;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!rx_calm && $urandom_range(0, 99) < 8) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned calm_run;
    int unsigned gap;
    logic        op;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_DRAW;
    in_ch.seed_value = '0;
    out_ch.ready     = 1'b0;
    err_cnt          = 0;
    calm_run         = 0;

    // Directed: draw from the reset seed, draws ignore seed_value,
    // zero and all-ones seeds, single bits, back-to-back loads.
    add_req(OP_DRAW, '0, 0, 0);
    add_req(OP_DRAW, ALL_ONES, 0, 0);
    add_req(OP_LOAD, '0, 0, 0);
    add_req(OP_DRAW, 64'h5555555555555555, 0, 0);
    add_req(OP_LOAD, ALL_ONES, 2, 0);
    add_req(OP_DRAW, '0, 0, 0);
    add_req(OP_LOAD, 64'h0000000000000001, 0, 0);
    add_req(OP_LOAD, 64'h8000000000000000, 0, 0);
    add_req(OP_DRAW, 64'haaaaaaaaaaaaaaaa, 0, 0);
    add_req(OP_LOAD, 64'h5555555555555555, 0, 0);
    add_req(OP_LOAD, 64'haaaaaaaaaaaaaaaa, 0, 0);
    add_req(OP_LOAD, '0, 0, 0);
    add_req(OP_LOAD, ALL_ONES, 0, 0);
    add_req(OP_DRAW, '0, 5, 0);
    add_req(OP_LOAD, 64'hfffffffffffffffe, 0, 1);
    add_req(OP_DRAW, 64'h7fffffffffffffff, 0, 0);
    add_req(OP_LOAD, SEED_INIT, 0, 0);
    add_req(OP_DRAW, '0, 0, 0);
    add_req(OP_LOAD, 64'h0123456789abcdef, 0, 1);
    add_req(OP_LOAD, 64'hfedcba9876543210, 0, 0);

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (calm_run == 0 && $urandom_range(0, 29) == 0) calm_run = $urandom_range(10, 40);
      if (calm_run != 0) begin
        gap = 0;
        calm_run--;
      end else begin
        gap = pick_gap();
      end
      op = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_DRAW;
      add_req(op, (op == OP_LOAD) ? pick_seed() : {$urandom, $urandom}, gap,
              ($urandom_range(0, 99) == 0));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_ch.valid || value_q.size() != 0) @(posedge clk);
    repeat (prrg_pkg::ROUNDS + 8) @(posedge clk);

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 3_500_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/prrg_pkg.sv
hdl/prrg_if.sv
hdl/prrg_round.sv
hdl/popcount_rotate_random_generator_top.sv
dv/popcount_rotate_random_generator_top_tb.sv
